// ----- sv/uarx_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uarx_pkg: shared types and codes for the serial receive FIFO
// Request and result item layouts, request kinds and sequencer states.
// ----------------------------------------------------------------------------
package uarx_pkg;

  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 5;
  localparam int FILL_W  = 4;
  localparam int GOOD_W  = 16;
  localparam int ERR_W   = 8;

  // Request kinds
  localparam logic REQ_RX   = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [BYTE_W-1:0]  rx_byte;
    logic               frame_error;
    logic               overrun_error;
    logic               parity_error;
    logic [COUNT_W-1:0] read_count;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              data_valid;
    logic              last;
    logic [FILL_W-1:0] fill_level;
    logic [GOOD_W-1:0] good_byte_count;
    logic [ERR_W-1:0]  frame_error_count;
    logic [ERR_W-1:0]  overrun_error_count;
    logic [ERR_W-1:0]  parity_error_count;
    logic [ERR_W-1:0]  dropped_oldest_count;
  } rsp_t;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_t;

endpackage
`default_nettype wire

// ----- sv/uarx_ring.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uarx_ring: byte store of the receive ring
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module uarx_ring #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [AW-1:0]              waddr,
  input  wire logic [uarx_pkg::BYTE_W-1:0] wdata,
  input  wire logic                       re,
  input  wire logic [AW-1:0]              raddr,
  output      logic [uarx_pkg::BYTE_W-1:0] rdata
);

  logic [uarx_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- sv/uarx_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uarx_ctrl: pointer, counter and pop sequencer of the receive FIFO
// Screens received bytes, pushes good ones with drop-oldest on full, and
// walks the ring one entry a cycle for read requests.
// ----------------------------------------------------------------------------
module uarx_ctrl #(
  parameter int RING_DEPTH = 16,
  parameter int PW         = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire uarx_pkg::req_t              req,
  output      logic                        busy,
  output      logic                        strobe,
  output      uarx_pkg::rsp_t              result,
  output      logic                        ring_we,
  output      logic [PW-1:0]               ring_waddr,
  output      logic [uarx_pkg::BYTE_W-1:0] ring_wdata,
  output      logic                        ring_re,
  output      logic [PW-1:0]               ring_raddr,
  input  wire logic [uarx_pkg::BYTE_W-1:0] ring_rdata
);

  localparam int CW = (PW > uarx_pkg::COUNT_W) ? PW : uarx_pkg::COUNT_W;
  localparam int LW = (PW > uarx_pkg::FILL_W) ? PW : uarx_pkg::FILL_W;
  localparam logic [PW-1:0] PTR_LAST  = PW'(RING_DEPTH - 1);
  localparam logic [PW-1:0] DEPTH_MOD = PW'(RING_DEPTH);

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] fill_of(input logic [PW-1:0] w, input logic [PW-1:0] r);
    return (w >= r) ? (w - r) : (w + DEPTH_MOD - r);
  endfunction

  uarx_pkg::state_t state, state_next;
  logic [PW-1:0] wp, wp_next, rp, rp_next;
  logic [CW-1:0] remaining, remaining_next;
  logic [uarx_pkg::GOOD_W-1:0] good_bytes, good_bytes_next;
  logic [uarx_pkg::ERR_W-1:0] frame_errors, frame_errors_next;
  logic [uarx_pkg::ERR_W-1:0] overrun_errors, overrun_errors_next;
  logic [uarx_pkg::ERR_W-1:0] parity_errors, parity_errors_next;
  logic [uarx_pkg::ERR_W-1:0] dropped_oldest, dropped_oldest_next;
  logic pend_valid, pend_valid_next;
  logic pend_dv, pend_dv_next;
  logic pend_last, pend_last_next;
  logic [PW-1:0] pend_fill, pend_fill_next;

  logic [PW-1:0] wp_bump, rp_bump, fill_cur;
  logic [CW-1:0] want, have, npop;
  logic          any_err;
  logic [LW-1:0] fill_ext;

  always_comb begin
    wp_bump  = bump(wp);
    rp_bump  = bump(rp);
    fill_cur = fill_of(wp, rp);
    want     = CW'(req.read_count);
    have     = CW'(fill_cur);
    npop     = (want < have) ? want : have;
    any_err  = req.frame_error | req.overrun_error | req.parity_error;

    state_next          = state;
    wp_next             = wp;
    rp_next             = rp;
    remaining_next      = remaining;
    good_bytes_next     = good_bytes;
    frame_errors_next   = frame_errors;
    overrun_errors_next = overrun_errors;
    parity_errors_next  = parity_errors;
    dropped_oldest_next = dropped_oldest;
    pend_valid_next     = 1'b0;
    pend_dv_next        = 1'b0;
    pend_last_next      = 1'b1;
    pend_fill_next      = fill_cur;
    ring_we             = 1'b0;
    ring_waddr          = wp;
    ring_wdata          = req.rx_byte;
    ring_re             = 1'b0;
    ring_raddr          = rp;

    unique case (state)
      uarx_pkg::ST_IDLE: begin
        if (start) begin
          if (req.req_type == uarx_pkg::REQ_RX) begin
            pend_valid_next = 1'b1;
            if (any_err) begin
              if (req.frame_error) frame_errors_next = frame_errors + 1'b1;
              if (req.overrun_error) overrun_errors_next = overrun_errors + 1'b1;
              if (req.parity_error) parity_errors_next = parity_errors + 1'b1;
            end else begin
              good_bytes_next = good_bytes + 1'b1;
              ring_we         = 1'b1;
              wp_next         = wp_bump;
              // Full ring: push over the oldest entry
              if (wp_bump == rp) begin
                rp_next             = rp_bump;
                dropped_oldest_next = dropped_oldest + 1'b1;
                pend_fill_next      = fill_of(wp_bump, rp_bump);
              end else begin
                pend_fill_next = fill_of(wp_bump, rp);
              end
            end
          end else if (npop == '0) begin
            pend_valid_next = 1'b1;
          end else begin
            remaining_next = npop;
            state_next     = uarx_pkg::ST_POP;
          end
        end
      end
      uarx_pkg::ST_POP: begin
        // Issue one read a cycle; data shows up with the pending item
        ring_re         = 1'b1;
        rp_next         = rp_bump;
        remaining_next  = remaining - CW'(1);
        pend_valid_next = 1'b1;
        pend_dv_next    = 1'b1;
        pend_last_next  = (remaining == CW'(1));
        pend_fill_next  = fill_of(wp, rp_bump);
        if (remaining == CW'(1)) begin
          state_next = uarx_pkg::ST_IDLE;
        end
      end
      default: state_next = uarx_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= uarx_pkg::ST_IDLE;
      wp             <= '0;
      rp             <= '0;
      remaining      <= '0;
      good_bytes     <= '0;
      frame_errors   <= '0;
      overrun_errors <= '0;
      parity_errors  <= '0;
      dropped_oldest <= '0;
      pend_valid     <= 1'b0;
    end else begin
      state          <= state_next;
      wp             <= wp_next;
      rp             <= rp_next;
      remaining      <= remaining_next;
      good_bytes     <= good_bytes_next;
      frame_errors   <= frame_errors_next;
      overrun_errors <= overrun_errors_next;
      parity_errors  <= parity_errors_next;
      dropped_oldest <= dropped_oldest_next;
      pend_valid     <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_dv   <= pend_dv_next;
    pend_last <= pend_last_next;
    pend_fill <= pend_fill_next;
  end

  assign busy     = (state != uarx_pkg::ST_IDLE);
  assign strobe   = pend_valid;
  assign fill_ext = LW'(pend_fill);

  always_comb begin
    result.read_data            = pend_dv ? ring_rdata : '0;
    result.data_valid           = pend_dv;
    result.last                 = pend_last;
    result.fill_level           = fill_ext[uarx_pkg::FILL_W-1:0];
    result.good_byte_count      = good_bytes;
    result.frame_error_count    = frame_errors;
    result.overrun_error_count  = overrun_errors;
    result.parity_error_count   = parity_errors;
    result.dropped_oldest_count = dropped_oldest;
  end

endmodule
`default_nettype wire

// ----- sv/uart_rx_overwrite_fifo_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uart_rx_overwrite_fifo_top: receive FIFO of a serial port, drop-oldest ring
// Received-byte item: one result in the cycle after acceptance; busy stays low.
// Read item of n pops: busy while in the pop state; n results, one per cycle,
// each with its registered ring read, set by the single read port of the ring memory.
// Read with nothing to pop: one result in the cycle after acceptance.
// Synchronous reset empties the ring and clears all counters; results cannot stall.
// ----------------------------------------------------------------------------
module uart_rx_overwrite_fifo_top #(
  parameter int RING_DEPTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire uarx_pkg::req_t req,
  output      logic           busy,
  output      logic           strobe,
  output      uarx_pkg::rsp_t result
);

  localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  logic                        ring_we;
  logic [PW-1:0]               ring_waddr;
  logic [uarx_pkg::BYTE_W-1:0] ring_wdata;
  logic                        ring_re;
  logic [PW-1:0]               ring_raddr;
  logic [uarx_pkg::BYTE_W-1:0] ring_rdata;

  uarx_ctrl #(
    .RING_DEPTH (RING_DEPTH),
    .PW         (PW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .req        (req),
    .busy       (busy),
    .strobe     (strobe),
    .result     (result),
    .ring_we    (ring_we),
    .ring_waddr (ring_waddr),
    .ring_wdata (ring_wdata),
    .ring_re    (ring_re),
    .ring_raddr (ring_raddr),
    .ring_rdata (ring_rdata)
  );

  uarx_ring #(
    .DEPTH (RING_DEPTH),
    .AW    (PW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .re    (ring_re),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

endmodule
`default_nettype wire
